// ----- hw/rtl/q2e_pkg.sv -----
package q2e_pkg;

  // Default number of CORDIC micro-rotations.
  localparam int unsigned DefaultStages = 16;
  localparam int unsigned MaxStages = 24;

  // Datapath widths: Q28 products of Q2.14 operands need 32 bits, their doubled sums 34; CORDIC
  // growth and the negation need a few more.
  localparam int unsigned VecW = 40;
  localparam int unsigned AccW = 34;
  localparam int unsigned SqW = 64;

  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [AccW-1:0] acc_t;

  // Arctangent constants, pi = 2^31.
  function automatic acc_t atan_const(input logic [4:0] idx);
    acc_t r;
    case (idx)
      5'd0: r = 34'sd536870912;
      5'd1: r = 34'sd316933406;
      5'd2: r = 34'sd167458907;
      5'd3: r = 34'sd85004756;
      5'd4: r = 34'sd42667331;
      5'd5: r = 34'sd21354465;
      5'd6: r = 34'sd10679838;
      5'd7: r = 34'sd5340245;
      5'd8: r = 34'sd2670163;
      5'd9: r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/q2e_cordic.sv -----
// Pipelined vectoring CORDIC: one micro-rotation per register stage.
// Holds its contents when en is low.
module q2e_cordic
  import q2e_pkg::*;
#(
  parameter int unsigned STAGES = DefaultStages
) (
  input  logic        clk,
  input  logic        en,
  input  vec_t        num,
  input  vec_t        den,
  output logic [15:0] angle
);

  vec_t xs [STAGES+1];
  vec_t ys [STAGES+1];
  acc_t as [STAGES+1];
  logic zs [STAGES+1];

  // Pre-rotation stage: fold negative denominators into the right half plane.
  always_ff @(posedge clk) begin
    if (en) begin
      zs[0] <= (num == '0) && (den == '0);
      if (den < 0) begin
        xs[0] <= -den;
        ys[0] <= -num;
        as[0] <= (num >= 0) ? acc_t'(64'sd2147483648) : acc_t'(-64'sd2147483648);
      end else begin
        xs[0] <= den;
        ys[0] <= num;
        as[0] <= '0;
      end
    end
  end

  // Micro-rotation stages.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zs[i+1] <= zs[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          as[i+1] <= as[i] + atan_const(5'(i));
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          as[i+1] <= as[i] - atan_const(5'(i));
        end
      end
    end
  end

  // Round to a 16-bit binary angle.
  acc_t rounded;
  assign rounded = as[STAGES] + acc_t'(32768);
  assign angle = zs[STAGES] ? 16'd0 : rounded[31:16];

endmodule

// ----- hw/rtl/quaternion_to_euler.sv -----
// Channel   Dir  tdata fields (low bit up)                       tuser
// s_axis    in   quat_x, quat_y, quat_z, quat_w (16 b each)        -
// m_axis    out  pitch_angle, yaw_angle, roll_angle (16 b each)    pitch_clamped
//
// One request per cycle unless m_axis stalls. Stages: an input register,
// a product stage and a sum stage, 32 square-root stages (one result bit each),
// the CORDIC pre-rotation and CORDIC_STAGES micro-rotations (up to MaxStages).
// Most of the depth is the square root.
// Synchronous reset clears the valid bits only. A stall on m_axis freezes the
// whole pipeline; s_axis_tready falls only while the output is full and held.
module quaternion_to_euler
  import q2e_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = DefaultStages
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // pitch_angle, yaw_angle, roll_angle
  output logic        m_axis_tuser    // pitch_clamped
);

  localparam int unsigned NStg = (CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES;
  localparam int unsigned SqSteps = 32;
  localparam int unsigned Lat = 3 + SqSteps + 1 + NStg;

  logic en;
  logic [Lat-1:0] vld;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Lat-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_axis_tvalid};
    end
  end

  // Stage 1: register inputs.
  logic signed [15:0] qx, qy, qz, qw;
  always_ff @(posedge clk) begin
    if (en) begin
      qx <= s_axis_tdata[15:0];
      qy <= s_axis_tdata[31:16];
      qz <= s_axis_tdata[47:32];
      qw <= s_axis_tdata[63:48];
    end
  end

  // Stage 2: products.
  logic signed [31:0] p_wx, p_zy, p_wy, p_xz, p_wz, p_xy, p_xx, p_yy, p_zz;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= qw * qx;
      p_zy <= qz * qy;
      p_wy <= qw * qy;
      p_xz <= qx * qz;
      p_wz <= qw * qz;
      p_xy <= qy * qx;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
    end
  end

  // Stage 3: sums into Q28.
  vec_t s_v, yn, yd, rn, rd;
  always_ff @(posedge clk) begin
    if (en) begin
      s_v <= (vec_t'(p_wx) - vec_t'(p_zy)) <<< 1;
      yn  <= (vec_t'(p_wy) + vec_t'(p_xz)) <<< 1;
      yd  <= vec_t'(64'sd268435456) - ((vec_t'(p_xx) + vec_t'(p_yy)) <<< 1);
      rn  <= (vec_t'(p_wz) + vec_t'(p_xy)) <<< 1;
      rd  <= vec_t'(64'sd268435456) - ((vec_t'(p_xx) + vec_t'(p_zz)) <<< 1);
    end
  end

  // Clamp decision and square-root operand.
  logic [VecW-1:0] abs_s;
  logic clamp_in;
  logic [SqW-1:0] sq_in;
  assign abs_s = s_v[VecW-1] ? VecW'(-s_v) : VecW'(s_v);
  assign clamp_in = abs_s >= VecW'(64'd268435456);
  assign sq_in = clamp_in ? '0 : ((SqW'(1) << 56) - SqW'(abs_s[28:0]) * SqW'(abs_s[28:0]));

  // Square root, one result bit per stage; other terms ride alongside.
  logic [SqW-1:0] rem [SqSteps+1];
  logic [SqW-1:0] res [SqSteps+1];
  vec_t d_s [SqSteps+1];
  vec_t d_yn [SqSteps+1];
  vec_t d_yd [SqSteps+1];
  vec_t d_rn [SqSteps+1];
  vec_t d_rd [SqSteps+1];
  logic d_cl [SqSteps+1];

  assign rem[0] = sq_in;
  assign res[0] = '0;
  assign d_s[0] = s_v;
  assign d_yn[0] = yn;
  assign d_yd[0] = yd;
  assign d_rn[0] = rn;
  assign d_rd[0] = rd;
  assign d_cl[0] = clamp_in;

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    localparam logic [SqW-1:0] Bit = SqW'(1) << (62 - 2 * k);
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= res[k] + Bit) begin
          rem[k+1] <= rem[k] - (res[k] + Bit);
          res[k+1] <= (res[k] >> 1) + Bit;
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k] >> 1;
        end
        d_s[k+1] <= d_s[k];
        d_yn[k+1] <= d_yn[k];
        d_yd[k+1] <= d_yd[k];
        d_rn[k+1] <= d_rn[k];
        d_rd[k+1] <= d_rd[k];
        d_cl[k+1] <= d_cl[k];
      end
    end
  end

  // Clamp flag and sign follow the CORDIC depth.
  logic [NStg:0] cl_d;
  logic [NStg:0] sn_d;
  always_ff @(posedge clk) begin
    if (en) begin
      cl_d <= {cl_d[NStg-1:0], d_cl[SqSteps]};
      sn_d <= {sn_d[NStg-1:0], d_s[SqSteps][VecW-1]};
    end
  end

  logic [15:0] pitch_c, yaw_a, roll_a;

  q2e_cordic #(.STAGES(NStg)) u_pitch (
    .clk(clk), .en(en), .num(d_s[SqSteps]),
    .den(vec_t'(res[SqSteps][31:0])), .angle(pitch_c)
  );
  q2e_cordic #(.STAGES(NStg)) u_yaw (
    .clk(clk), .en(en), .num(d_yn[SqSteps]), .den(d_yd[SqSteps]), .angle(yaw_a)
  );
  q2e_cordic #(.STAGES(NStg)) u_roll (
    .clk(clk), .en(en), .num(d_rn[SqSteps]), .den(d_rd[SqSteps]), .angle(roll_a)
  );

  // Output: clamped pitch replaces the CORDIC result.
  logic [15:0] pitch_a;
  assign pitch_a = cl_d[NStg] ? (sn_d[NStg] ? 16'hC000 : 16'h4000) : pitch_c;
  assign m_axis_tdata = {roll_a, yaw_a, pitch_a};
  assign m_axis_tuser = cl_d[NStg];

endmodule

// ----- hw/rtl/q2e_checker.sv -----
// Port-level checks of the converter.
module q2e_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // Input is ready whenever output is not stalled.
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input blocked without stall");

  // A clamped pitch is exactly plus or minus a quarter turn.
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[15:0] == 16'h4000) || (m_axis_tdata[15:0] == 16'hC000))
    else $error("bad clamped pitch");

  // No result right after reset.
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");

endmodule

bind quaternion_to_euler q2e_checker u_q2e_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

// ----- verif/quaternion_to_euler_tb.sv -----
`timescale 1ns / 100ps

module quaternion_to_euler_tb;
  import q2e_pkg::*;

  localparam int unsigned Stages = DefaultStages;
  localparam int unsigned Latency = 36 + Stages;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned RandomCount = 600;
  localparam int unsigned DirectedCount = 14;
  localparam int unsigned CheckAll = 0;
  localparam int unsigned CheckTyped = 1;

  typedef struct packed {
    logic signed [15:0] qw;
    logic signed [15:0] qz;
    logic signed [15:0] qy;
    logic signed [15:0] qx;
  } quat_t;

  typedef struct packed {
    logic               clamped;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
  } euler_t;

  typedef struct {
    quat_t  q;
    int     mode;
    euler_t typed;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  euler_t angles_pending[$];
  int     errors;
  int     idle_cycles = 0;
  bit     sending_done;

  quaternion_to_euler #(.CORDIC_STAGES(Stages)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Integer square root of a 64-bit unsigned value, bit by bit.
  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC returning atan2(num, den) as a 16-bit binary angle.
  function automatic logic [15:0] vector_angle(input longint num, input longint den);
    longint xv, yv, acc, dx, dy;
    xv = den;
    yv = num;
    acc = 0;
    if (num == 0 && den == 0) return 16'd0;
    if (xv < 0) begin
      xv = -xv;
      yv = -yv;
      acc = (num >= 0) ? (64'sd1 << 31) : -(64'sd1 << 31);
    end
    for (int i = 0; i < Stages && i < MaxStages; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx;
        yv -= dy;
        acc += longint'(atan_const(5'(i)));
      end else begin
        xv -= dx;
        yv += dy;
        acc -= longint'(atan_const(5'(i)));
      end
    end
    acc = (acc + 32768) >>> 16;
    return acc[15:0];
  endfunction

  function automatic euler_t predict_angles(input quat_t q);
    longint x, y, z, w, s, abs_s, one;
    euler_t e;
    x = q.qx;
    y = q.qy;
    z = q.qz;
    w = q.qw;
    one = 64'sd1 << 28;
    s = 2 * (w * x - z * y);
    abs_s = (s < 0) ? -s : s;
    if (abs_s >= one) begin
      e.pitch = (s < 0) ? -16'sd16384 : 16'sd16384;
      e.clamped = 1'b1;
    end else begin
      e.pitch = vector_angle(s, longint'(int_sqrt((64'd1 << 56) - abs_s * abs_s)));
      e.clamped = 1'b0;
    end
    e.yaw = vector_angle(2 * (w * y + x * z), one - 2 * (x * x + y * y));
    e.roll = vector_angle(2 * (w * z + y * x), one - 2 * (x * x + z * z));
    return e;
  endfunction

  // Valid drops only during an idle gap, so back-to-back requests keep it high.
  task automatic send_quat(input quat_t q, input euler_t exp_e);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= q;
    angles_pending.push_back(exp_e);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic quat_t random_quat();
    quat_t q;
    case ($urandom_range(0, 3))
      0: q = {$urandom, $urandom};
      // Components within plus or minus one half.
      1: begin
        q.qx = 16'(int'($urandom_range(0, 16384)) - 8192);
        q.qy = 16'(int'($urandom_range(0, 16384)) - 8192);
        q.qz = 16'(int'($urandom_range(0, 16384)) - 8192);
        q.qw = 16'(int'($urandom_range(0, 16384)) - 8192);
      end
      // Near gimbal lock: x close to 0.707, w close to plus or minus 0.707.
      2: begin
        q.qx = 16'(11585 + int'($urandom_range(0, 200)) - 100);
        q.qw = 16'(($urandom_range(0, 1) ? 11585 : -11585) +
                   int'($urandom_range(0, 200)) - 100);
        q.qy = 16'(int'($urandom_range(0, 400)) - 200);
        q.qz = 16'(int'($urandom_range(0, 400)) - 200);
      end
      default: begin
        q.qx = 16'($urandom_range(0, 65535));
        q.qy = 16'(int'($urandom_range(0, 2000)) - 1000);
        q.qz = 16'(int'($urandom_range(0, 2000)) - 1000);
        q.qw = 16'($urandom_range(0, 65535));
      end
    endcase
    return q;
  endfunction

  // Stimulus: directed table, then random quaternions.
  initial begin
    dir_row_t dir_rows[DirectedCount];
    quat_t q;
    dir_rows[0] = '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, CheckTyped,
                    '{1'b0, 16'sd0, 16'sd0, 16'sd0}};
    dir_rows[1] = '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, CheckAll, '0};
    dir_rows[2] = '{'{16'sd11585, 16'sd0, 16'sd0, 16'sd11585}, CheckAll, '0};
    dir_rows[3] = '{'{-16'sd11585, 16'sd0, 16'sd0, 16'sd11585}, CheckAll, '0};
    dir_rows[4] = '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd16384}, CheckAll, '0};
    dir_rows[5] = '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, CheckAll, '0};
    dir_rows[6] = '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, CheckAll, '0};
    dir_rows[7] = '{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, CheckAll, '0};
    dir_rows[8] = '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0}, CheckAll, '0};
    dir_rows[9] = '{'{16'sd0, 16'sd16384, 16'sd0, 16'sd0}, CheckAll, '0};
    dir_rows[10] = '{'{16'sd0, -16'sd16384, 16'sd0, 16'sd0}, CheckAll, '0};
    dir_rows[11] = '{'{-16'sd1, 16'sd0, -16'sd1, 16'sd1}, CheckAll, '0};
    dir_rows[12] = '{'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768}, CheckAll, '0};
    dir_rows[13] = '{'{16'sd5793, 16'sd8192, -16'sd5793, 16'sd8192}, CheckAll, '0};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    sending_done = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_quat(dir_rows[i].q, (dir_rows[i].mode == CheckTyped) ?
                dir_rows[i].typed : predict_angles(dir_rows[i].q));
    end
    for (int n = 0; n < RandomCount; n++) begin
      // Let the pipeline drain once midway.
      if (n == RandomCount / 2) begin
        s_axis_tvalid <= 1'b0;
        while (angles_pending.size() != 0) @(posedge clk);
      end
      q = random_quat();
      send_quat(q, predict_angles(q));
    end
    s_axis_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // Result side: random stall per request and comparison.
  initial begin
    euler_t got;
    euler_t want;
    int stall;
    m_axis_tready = 1'b0;
    errors = 0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got = {m_axis_tuser, m_axis_tdata};
      if (angles_pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = angles_pending.pop_front();
        if (got.pitch !== want.pitch)
          $display("%0t: pitch expected %0d actual %0d", $time, want.pitch, got.pitch);
        if (got.yaw !== want.yaw)
          $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
        if (got.roll !== want.roll)
          $display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
        if (got.clamped !== want.clamped)
          $display("%0t: clamp expected %0b actual %0b", $time, want.clamped, got.clamped);
        if (got !== want) errors++;
      end
    end
  end

  // Watchdog on cycles with no accepted request on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (!rst && idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // End of run.
  initial begin
    @(negedge rst);
    wait (sending_done);
    while (angles_pending.size() != 0) @(posedge clk);
    repeat (Latency + 20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
